### hdl/hsv_pkg.sv
// Package with constants, stage types and arithmetic helpers of the HSV to RGB565 converter.
package hsv_pkg;

  localparam logic [8:0]  HUE_MAX    = 9'd359;
  localparam logic [6:0]  PCT_MAX    = 7'd100;
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [8:0]  REGION_SPAN = 9'd43;
  localparam logic [7:0]  REM_SCALE  = 8'd6;
  localparam logic [7:0]  RED_MASK   = 8'hF8;
  localparam logic [7:0]  GREEN_MASK = 8'hFC;

  // Reciprocals: x / 100 = (x * 5243) >> 19 for x <= 25500,
  // hue / 43 = (hue * 3049) >> 17 for hue <= 359.
  localparam logic [12:0] RECIP_PCT   = 13'd5243;
  localparam int          SHIFT_PCT   = 19;
  localparam logic [11:0] RECIP_SPAN  = 12'd3049;
  localparam int          SHIFT_SPAN  = 17;

  localparam logic [3:0] SEG_RED_RISE   = 4'd0;
  localparam logic [3:0] SEG_GREEN_HOLD = 4'd1;
  localparam logic [3:0] SEG_GREEN_FALL = 4'd2;
  localparam logic [3:0] SEG_BLUE_HOLD  = 4'd3;
  localparam logic [3:0] SEG_BLUE_FALL  = 4'd4;

  localparam logic FUNC_GRAY = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  gray;
    logic [14:0] s_x;
    logic [14:0] v_x;
    logic [8:0]  hue;
    logic [20:0] hue_prod;
  } st1_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  gray;
    logic [7:0]  s;
    logic [7:0]  v;
    logic [3:0]  region;
    logic [7:0]  rem;
  } st2_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  gray;
    logic [7:0]  v;
    logic [3:0]  region;
    logic [15:0] prod_p;
    logic [15:0] prod_sr;
    logic [15:0] prod_sn;
  } st3_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  gray;
    logic [7:0]  v;
    logic [3:0]  region;
    logic [7:0]  p;
    logic [15:0] prod_q;
    logic [15:0] prod_t;
  } st4_t;

  // Exact truncating division by 255 for x <= 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    logic [7:0] rm;
    logic [7:0] gm;
    rm = r & RED_MASK;
    gm = g & GREEN_MASK;
    return {rm[7:3], gm[7:2], b[7:3]};
  endfunction

endpackage

### hdl/hsv_if.sv
// Request and response channel interfaces of the HSV to RGB565 converter.
interface hsv_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [8:0] hue;
  logic [6:0] sat_pct;
  logic [6:0] val_pct;
  logic [7:0] gray_level;

  modport source(output valid, func, hue, sat_pct, val_pct, gray_level, input ready);
  modport sink(input valid, func, hue, sat_pct, val_pct, gray_level, output ready);
endinterface

interface hsv_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] color_word;

  modport source(output valid, color_word, input ready);
  modport sink(input valid, color_word, output ready);
endinterface

### hdl/hsv_to_rgb565.sv
// Five-stage pipelined HSV or gray level to RGB565 converter.
//
//   channel  role    carries
//   req      sink    func, hue, sat_pct, val_pct, gray_level
//   rsp      source  color_word
//
// One request is taken per clock while req.ready is high; each result passes through st1, st2, st3, st4 and color.
// The depth is set by the two chained multiply and divide-by-255 steps of q and t.
// Reset empties all five stages at once; payload registers are not reset.
// A stalled response holds its stage, and the stages behind it fill before req.ready falls.
module hsv_to_rgb565
  import hsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hsv_req_if.sink    req,
  hsv_rsp_if.source  rsp
);

  logic        v1, v2, v3, v4, v5;
  logic        en1, en2, en3, en4, en5;
  st1_t        st1;
  st2_t        st2;
  st3_t        st3;
  st4_t        st4;
  logic [15:0] color;

  st1_t        st1_next;
  st2_t        st2_next;
  st3_t        st3_next;
  st4_t        st4_next;
  logic [15:0] color_next;

  logic [6:0]  sp_c;
  logic [6:0]  vp_c;
  logic [27:0] s_prod;
  logic [27:0] v_prod;
  logic [8:0]  s_full;
  logic [8:0]  v_full;
  logic [8:0]  seg_base;
  logic [8:0]  offs;
  logic [7:0]  sr_div;
  logic [7:0]  sn_div;
  logic [7:0]  q;
  logic [7:0]  t;
  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;

  assign en5 = !v5 || rsp.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;
  assign rsp.valid = v5;
  assign rsp.color_word = color;

  always_comb begin
    sp_c = (req.sat_pct > PCT_MAX) ? PCT_MAX : req.sat_pct;
    vp_c = (req.val_pct > PCT_MAX) ? PCT_MAX : req.val_pct;
    st1_next.func = req.func;
    st1_next.gray = req.gray_level;
    st1_next.hue = (req.hue > HUE_MAX) ? HUE_MAX : req.hue;
    st1_next.s_x = 15'({sp_c, 8'd0}) - 15'(sp_c);
    st1_next.v_x = 15'({vp_c, 8'd0}) - 15'(vp_c);
    st1_next.hue_prod = 21'(st1_next.hue) * 21'(RECIP_SPAN);
  end

  always_comb begin
    s_prod = 28'(st1.s_x) * 28'(RECIP_PCT);
    v_prod = 28'(st1.v_x) * 28'(RECIP_PCT);
    s_full = s_prod[SHIFT_PCT+8:SHIFT_PCT];
    v_full = v_prod[SHIFT_PCT+8:SHIFT_PCT];
    st2_next.func = st1.func;
    st2_next.gray = st1.gray;
    st2_next.s = s_full[7:0];
    st2_next.v = v_full[7:0];
    st2_next.region = st1.hue_prod[SHIFT_SPAN+3:SHIFT_SPAN];
    seg_base = 9'(st2_next.region) * REGION_SPAN;
    offs = st1.hue - seg_base;
    st2_next.rem = 8'(offs[5:0]) * REM_SCALE;
  end

  always_comb begin
    st3_next.func = st2.func;
    st3_next.gray = st2.gray;
    st3_next.v = st2.v;
    st3_next.region = st2.region;
    st3_next.prod_p = 16'(st2.v) * 16'(FULL_SCALE - st2.s);
    st3_next.prod_sr = 16'(st2.s) * 16'(st2.rem);
    st3_next.prod_sn = 16'(st2.s) * 16'(FULL_SCALE - st2.rem);
  end

  always_comb begin
    sr_div = div255(st3.prod_sr);
    sn_div = div255(st3.prod_sn);
    st4_next.func = st3.func;
    st4_next.gray = st3.gray;
    st4_next.v = st3.v;
    st4_next.region = st3.region;
    st4_next.p = div255(st3.prod_p);
    st4_next.prod_q = 16'(st3.v) * 16'(FULL_SCALE - sr_div);
    st4_next.prod_t = 16'(st3.v) * 16'(FULL_SCALE - sn_div);
  end

  always_comb begin
    q = div255(st4.prod_q);
    t = div255(st4.prod_t);
    case (st4.region)
      SEG_RED_RISE: begin
        r = st4.v; g = t; b = st4.p;
      end
      SEG_GREEN_HOLD: begin
        r = q; g = st4.v; b = st4.p;
      end
      SEG_GREEN_FALL: begin
        r = st4.p; g = st4.v; b = t;
      end
      SEG_BLUE_HOLD: begin
        r = st4.p; g = q; b = st4.v;
      end
      SEG_BLUE_FALL: begin
        r = t; g = st4.p; b = st4.v;
      end
      default: begin
        r = st4.v; g = st4.p; b = q;
      end
    endcase
    if (st4.func == FUNC_GRAY) begin
      color_next = pack565(st4.gray, st4.gray, st4.gray);
    end else begin
      color_next = pack565(r, g, b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= req.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) st1 <= st1_next;
    if (en2) st2 <= st2_next;
    if (en3) st3 <= st3_next;
    if (en4) st4 <= st4_next;
    if (en5) color <= color_next;
  end

  // A full first stage that cannot move must refuse a new request.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    (v1 && !en2) |-> !req.ready)
    else $error("request accepted while first stage is blocked");

  // Reset leaves no response pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("response valid right after reset");

  // The hue segment never exceeds eight and the remainder stays within 42 * 6.
  a_segment_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (st2.region <= 4'd8) && (st2.rem <= 8'd252))
    else $error("hue segment or remainder out of range");

  // The percent scaling never overflows eight bits.
  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> !s_full[8] && !v_full[8])
    else $error("scaled saturation or value overflows");

  // A stage that holds an item keeps it until the next stage takes it.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !en5) |=> v4 && $stable(st4))
    else $error("stalled stage lost its item");

endmodule
